// File: hdl/bus_mouse_adapter_top_macros.svh
// Assertion helpers shared by the adapter RTL.
`ifndef BUS_MOUSE_ADAPTER_TOP_MACROS_SVH
`define BUS_MOUSE_ADAPTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BMA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bus mouse adapter check failed");

// Next-cycle implication, disabled while reset is held.
`define BMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bus mouse adapter check failed");

`endif

// File: hdl/bma_pkg.sv
`default_nettype none
package bma_pkg;

    localparam int ACC_WIDTH_DEF = 16;
    localparam int MOVE_W        = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 3;

    typedef enum logic [1:0] {
        ACT_READ   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_TICK   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        PORT_DATA = 2'd0,
        PORT_SIG  = 2'd1,
        PORT_CTRL = 2'd2,
        PORT_CFG  = 2'd3
    } t_port;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THREE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_NUM = 2'd2;

    // data read nibble selects (control bits 6:5)
    localparam logic [1:0] DSEL_X_LO = 2'd0;
    localparam logic [1:0] DSEL_X_HI = 2'd1;
    localparam logic [1:0] DSEL_Y_LO = 2'd2;
    localparam logic [1:0] DSEL_Y_HI = 2'd3;

    localparam logic [7:0] CTRL_LOW   = 8'h0f;
    localparam logic [7:0] CTRL_RESET = 8'h0f;
    localparam logic [7:0] IRQ_BASE   = 8'h20;
    localparam logic [7:0] BYTE_ONES  = 8'hff;
    localparam logic [7:0] BYTE_MAX   = 8'h7f;
    localparam logic [7:0] BYTE_MIN   = 8'h80;
    localparam int         CHUNK_MAX  = 127;
    localparam int         CHUNK_MIN  = -128;
    localparam logic [2:0] IRQ_NUM_RESET = 3'd5;

    typedef struct packed {
        logic       timed_mode;
        logic       three_buttons;
        logic [2:0] irq_number;
    } t_cfg;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_raise;
        logic       irq_clear;
    } t_result;

    function automatic logic [7:0] clamp_byte(input logic [MOVE_W-1:0] v);
        if ($signed(v) > $signed(MOVE_W'(CHUNK_MAX))) begin
            return BYTE_MAX;
        end else if ($signed(v) < $signed(MOVE_W'(CHUNK_MIN))) begin
            return BYTE_MIN;
        end
        return v[7:0];
    endfunction

endpackage
`default_nettype wire

// File: hdl/bma_in_if.sv
`default_nettype none
interface bma_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    action;
    logic [1:0]                    port;
    logic [7:0]                    write_data;
    logic signed [bma_pkg::MOVE_W-1:0] move_x;
    logic signed [bma_pkg::MOVE_W-1:0] move_y;
    logic [2:0]                    buttons_raw;
    logic                          noise_bit;

    modport source (output valid, action, port, write_data, move_x, move_y,
                    buttons_raw, noise_bit, input ready);
    modport sink   (input valid, action, port, write_data, move_x, move_y,
                    buttons_raw, noise_bit, output ready);
endinterface
`default_nettype wire

// File: hdl/bma_out_if.sv
`default_nettype none
interface bma_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq_raise;
    logic       irq_clear;

    modport source (output valid, read_data, irq_raise, irq_clear, input ready);
    modport sink   (input valid, read_data, irq_raise, irq_clear, output ready);
endinterface
`default_nettype wire

// File: hdl/bus_mouse_adapter_top.sv
// Bus mouse adapter: one input word (bus read, bus write, host motion/button
// update or timer tick) is taken per clock and yields exactly one result word
// (read byte, IRQ raise, IRQ clear) in the next cycle from the output register.
// Throughput is one word per cycle; the input side stalls only while the
// output register holds a word the sink has not taken. All register effects
// of a word (nibble clear on data read, control reload, accumulators, button
// latch) land at the edge where it is accepted, so the next word sees them.
// Configuration (timed mode, three buttons, IRQ number) goes through
// i_cfg_we/i_cfg_index/i_cfg_data; the user must write it only while the
// adapter is idle, which the block does not enforce; index 3 is ignored.
// ACC_WIDTH sets the width of the saturating motion accumulators used in timed mode.
`default_nettype none
`include "bus_mouse_adapter_top_macros.svh"
module bus_mouse_adapter_top #(
    parameter int ACC_WIDTH = bma_pkg::ACC_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [bma_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bma_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bma_in_if.sink                              i_in,
    bma_out_if.source                           o_out
);

    bma_pkg::t_cfg    r_cfg;
    bma_pkg::t_result core_result;
    logic             core_load;
    logic             out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timed_mode    <= 1'b1;
            r_cfg.three_buttons <= 1'b0;
            r_cfg.irq_number    <= bma_pkg::IRQ_NUM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bma_pkg::CFG_TIMED:   r_cfg.timed_mode    <= i_cfg_data[0];
                bma_pkg::CFG_THREE:   r_cfg.three_buttons <= i_cfg_data[0];
                bma_pkg::CFG_IRQ_NUM: r_cfg.irq_number    <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // adapter state and per-word decode
    bma_core #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_free   (out_free),
        .i_in     (i_in),
        .o_load   (core_load),
        .o_result (core_result)
    );

    // result register toward the sink
    bma_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (core_load),
        .i_result (core_result),
        .o_free   (out_free),
        .o_out    (o_out)
    );

    // every accepted word produces a result on the next cycle
    `BMA_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, core_load, o_out.valid)
    // a stalled result blocks new input
    `BMA_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, o_out.valid && !o_out.ready, !i_in.ready)
    // raise and clear come from different word kinds
    `BMA_ASSERT_IMP(a_raise_clear_excl, i_clk, i_rst_n, o_out.valid,
                    !(o_out.irq_raise && o_out.irq_clear))
    // only reads return data
    `BMA_ASSERT_NEXT(a_data_only_on_read, i_clk, i_rst_n,
                     core_load && (i_in.action != bma_pkg::ACT_READ),
                     o_out.read_data == 8'h00)

endmodule
`default_nettype wire

// File: hdl/bma_core.sv
`default_nettype none
module bma_core #(
    parameter int ACC_WIDTH = bma_pkg::ACC_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bma_pkg::t_cfg    i_cfg,
    input  wire logic             i_free,
    bma_in_if.sink                i_in,
    output logic                  o_load,
    output bma_pkg::t_result      o_result
);

    localparam logic [ACC_WIDTH-1:0] CHUNK_HI = ACC_WIDTH'(bma_pkg::CHUNK_MAX);
    localparam logic [ACC_WIDTH-1:0] CHUNK_LO = ACC_WIDTH'(bma_pkg::CHUNK_MIN);

    logic                 r_en, n_en;
    logic                 r_tie, n_tie;
    logic                 r_hold, n_hold;
    logic [7:0]           r_cx, n_cx;
    logic [7:0]           r_cy, n_cy;
    logic [2:0]           r_latched, n_latched;
    logic [2:0]           r_mapped, n_mapped;
    logic [2:0]           r_prev, n_prev;
    logic [7:0]           r_control, n_control;
    logic [7:0]           r_sig, n_sig;
    logic [ACC_WIDTH-1:0] r_pend_x, n_pend_x;
    logic [ACC_WIDTH-1:0] r_pend_y, n_pend_y;

    logic [7:0]           mask;
    logic [7:0]           clamp_x, clamp_y, bit_sel;
    logic [2:0]           map_new;
    logic [3:0]           nib;
    logic [ACC_WIDTH+7:0] drain_x, drain_y;
    bma_pkg::t_result     res;

    // saturating add of a signed byte into the accumulator
    function automatic logic [ACC_WIDTH-1:0] sat_add(input logic [ACC_WIDTH-1:0] acc,
                                                      input logic [7:0] d);
        logic [ACC_WIDTH:0] s;
        s = {acc[ACC_WIDTH-1], acc} + {{(ACC_WIDTH-7){d[7]}}, d};
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
            return s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end
        return s[ACC_WIDTH-1:0];
    endfunction

    // {chunk, remaining accumulator}
    function automatic logic [ACC_WIDTH+7:0] drain(input logic [ACC_WIDTH-1:0] acc);
        if ($signed(acc) > $signed(CHUNK_HI)) begin
            return {bma_pkg::BYTE_MAX, acc - CHUNK_HI};
        end else if ($signed(acc) < $signed(CHUNK_LO)) begin
            return {bma_pkg::BYTE_MIN, acc - CHUNK_LO};
        end
        return {acc[7:0], {ACC_WIDTH{1'b0}}};
    endfunction

    assign i_in.ready = i_free;
    assign o_load     = i_in.valid && i_free;
    assign o_result   = res;

    assign mask    = bma_pkg::IRQ_BASE >> i_cfg.irq_number;
    assign clamp_x = bma_pkg::clamp_byte(i_in.move_x);
    assign clamp_y = bma_pkg::clamp_byte(i_in.move_y);
    assign bit_sel = 8'h01 << i_in.write_data[3:1];
    assign map_new = {i_in.buttons_raw[0], i_cfg.three_buttons & i_in.buttons_raw[2],
                      i_in.buttons_raw[1]};
    assign drain_x = drain(r_pend_x);
    assign drain_y = drain(r_pend_y);

    always_comb begin
        n_en      = r_en;
        n_tie     = r_tie;
        n_hold    = r_hold;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_latched = r_latched;
        n_mapped  = r_mapped;
        n_prev    = r_prev;
        n_control = r_control;
        n_sig     = r_sig;
        n_pend_x  = r_pend_x;
        n_pend_y  = r_pend_y;
        nib       = 4'h0;
        res       = '0;
        case (bma_pkg::t_action'(i_in.action))
            bma_pkg::ACT_READ: begin
                case (bma_pkg::t_port'(i_in.port))
                    bma_pkg::PORT_DATA: begin
                        case (r_control[6:5])
                            bma_pkg::DSEL_X_LO: begin
                                nib  = r_cx[3:0];
                                n_cx = {r_cx[7:4], 4'h0};
                            end
                            bma_pkg::DSEL_X_HI: begin
                                nib  = r_cx[7:4];
                                n_cx = {4'h0, r_cx[3:0]};
                            end
                            bma_pkg::DSEL_Y_LO: begin
                                nib  = r_cy[3:0];
                                n_cy = {r_cy[7:4], 4'h0};
                            end
                            default: begin
                                nib  = r_cy[7:4];
                                n_cy = {4'h0, r_cy[3:0]};
                            end
                        endcase
                        res.read_data = {~r_latched, 1'b0, nib};
                    end
                    bma_pkg::PORT_SIG: begin
                        res.read_data = r_sig;
                    end
                    bma_pkg::PORT_CTRL: begin
                        res.read_data = r_control;
                        n_control     = r_control | bma_pkg::CTRL_LOW;
                        if (r_tie) begin
                            n_control = (n_control & ~mask) | (i_in.noise_bit ? mask : 8'h00);
                        end
                    end
                    default: begin
                        res.read_data = r_en ? ((r_control | bma_pkg::CTRL_LOW) & ~mask)
                                             : bma_pkg::BYTE_ONES;
                    end
                endcase
            end
            bma_pkg::ACT_WRITE: begin
                case (bma_pkg::t_port'(i_in.port))
                    bma_pkg::PORT_DATA: begin
                        n_sig = r_sig;
                    end
                    bma_pkg::PORT_SIG: begin
                        n_sig = i_in.write_data;
                    end
                    bma_pkg::PORT_CTRL: begin
                        n_control     = i_in.write_data | bma_pkg::CTRL_LOW;
                        n_tie         = ~i_in.write_data[4];
                        n_hold        = i_in.write_data[7];
                        res.irq_clear = 1'b1;
                    end
                    default: begin
                        if (i_in.write_data[7]) begin
                            // mode set
                            n_en      = 1'b1;
                            n_tie     = 1'b1;
                            n_control = bma_pkg::CTRL_LOW & ~mask;
                        end else if (i_in.write_data[0]) begin
                            n_control = r_control | bit_sel;
                        end else begin
                            n_control = r_control & ~bit_sel;
                        end
                    end
                endcase
            end
            bma_pkg::ACT_UPDATE: begin
                if (r_en) begin
                    n_prev = i_in.buttons_raw;
                    if (i_in.move_x != '0 || i_in.move_y != '0 ||
                        i_in.buttons_raw != r_prev) begin
                        n_mapped = map_new;
                        if (i_cfg.timed_mode) begin
                            n_pend_x = sat_add(r_pend_x, clamp_x);
                            n_pend_y = sat_add(r_pend_y, clamp_y);
                        end else begin
                            res.irq_raise = 1'b1;
                            if (!r_hold) begin
                                n_cx      = clamp_x;
                                n_cy      = clamp_y;
                                n_latched = map_new;
                            end
                        end
                    end
                end
            end
            default: begin
                if (i_cfg.timed_mode) begin
                    res.irq_raise = r_tie;
                    if (!r_hold) begin
                        n_cx      = drain_x[ACC_WIDTH+7:ACC_WIDTH];
                        n_cy      = drain_y[ACC_WIDTH+7:ACC_WIDTH];
                        n_pend_x  = drain_x[ACC_WIDTH-1:0];
                        n_pend_y  = drain_y[ACC_WIDTH-1:0];
                        n_latched = r_mapped;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en      <= 1'b0;
            r_tie     <= 1'b0;
            r_hold    <= 1'b0;
            r_cx      <= '0;
            r_cy      <= '0;
            r_latched <= '0;
            r_mapped  <= '0;
            r_prev    <= '0;
            r_control <= bma_pkg::CTRL_RESET;
            r_sig     <= '0;
            r_pend_x  <= '0;
            r_pend_y  <= '0;
        end else if (o_load) begin
            r_en      <= n_en;
            r_tie     <= n_tie;
            r_hold    <= n_hold;
            r_cx      <= n_cx;
            r_cy      <= n_cy;
            r_latched <= n_latched;
            r_mapped  <= n_mapped;
            r_prev    <= n_prev;
            r_control <= n_control;
            r_sig     <= n_sig;
            r_pend_x  <= n_pend_x;
            r_pend_y  <= n_pend_y;
        end
    end

endmodule
`default_nettype wire

// File: hdl/bma_out_reg.sv
`default_nettype none
module bma_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire bma_pkg::t_result i_result,
    output logic                  o_free,
    bma_out_if.source             o_out
);

    logic             r_valid;
    bma_pkg::t_result r_result;

    // room when empty or when the held word leaves this cycle
    assign o_free = i_rst_n && (!r_valid || o_out.ready);

    assign o_out.valid     = r_valid;
    assign o_out.read_data = r_result.read_data;
    assign o_out.irq_raise = r_result.irq_raise;
    assign o_out.irq_clear = r_result.irq_clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule
`default_nettype wire

// File: dv/tb_bus_mouse_adapter_top.sv
`timescale 1ns / 1ps

module tb_bus_mouse_adapter_top;

    localparam int ACC_W = bma_pkg::ACC_WIDTH_DEF;
    // index 3 has no register behind it; the adapter must ignore it
    localparam logic [bma_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // One input word as the host and the bus present it.
    typedef struct packed {
        bma_pkg::t_action   action;
        bma_pkg::t_port     port;
        logic [7:0]         wdata;
        logic signed [15:0] move_x;
        logic signed [15:0] move_y;
        logic [2:0]         buttons;
        logic               noise;
    } t_mouse_word;

    // ------------------------------------------------------------------
    // Adapter tracker: mirrors the register file, the motion counters and
    // the accumulators, and keeps the replies each accepted word must give.
    // ------------------------------------------------------------------
    class mouse_adapter_tracker;
        bit         timed;
        bit         three;
        bit [2:0]   irq_num;
        bit         enabled;
        bit         tick_irq_en;
        bit         hold;
        bit [7:0]   cnt_x;
        bit [7:0]   cnt_y;
        bit [7:0]   ctrl;
        bit [7:0]   sig;
        bit [2:0]   btn_latched;
        bit [2:0]   btn_mapped;
        bit [2:0]   btn_prev;
        int         acc_x;
        int         acc_y;
        bma_pkg::t_result replies_due[$];
        int         failures;

        function new();
            timed = 1'b1;
            three = 1'b0;
            irq_num = bma_pkg::IRQ_NUM_RESET;
            enabled = 0;
            tick_irq_en = 0;
            hold = 0;
            cnt_x = '0;
            cnt_y = '0;
            ctrl = bma_pkg::CTRL_RESET;
            sig = '0;
            btn_latched = '0;
            btn_mapped = '0;
            btn_prev = '0;
            acc_x = 0;
            acc_y = 0;
            failures = 0;
        endfunction

        function void write_reg(logic [bma_pkg::CFG_IDX_W-1:0] idx,
                                logic [bma_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                bma_pkg::CFG_TIMED:   timed = data[0];
                bma_pkg::CFG_THREE:   three = data[0];
                bma_pkg::CFG_IRQ_NUM: irq_num = data;
                default: ;
            endcase
        endfunction

        function int clamp_move(logic signed [15:0] v);
            int w;
            w = v;
            if (w > bma_pkg::CHUNK_MAX) return bma_pkg::CHUNK_MAX;
            if (w < bma_pkg::CHUNK_MIN) return bma_pkg::CHUNK_MIN;
            return w;
        endfunction

        function int sat_add(int acc, int d);
            longint s;
            longint top;
            longint bot;
            top = (longint'(1) << (ACC_W - 1)) - 1;
            bot = -(longint'(1) << (ACC_W - 1));
            s = longint'(acc) + d;
            if (s > top) s = top;
            if (s < bot) s = bot;
            return int'(s);
        endfunction

        // Release one signed-byte chunk of an accumulator.
        function bit [7:0] drain_chunk(inout int acc);
            int chunk;
            if (acc > bma_pkg::CHUNK_MAX) begin
                chunk = bma_pkg::CHUNK_MAX;
                acc -= bma_pkg::CHUNK_MAX;
            end else if (acc < bma_pkg::CHUNK_MIN) begin
                chunk = bma_pkg::CHUNK_MIN;
                acc -= bma_pkg::CHUNK_MIN;
            end else begin
                chunk = acc;
                acc = 0;
            end
            return chunk[7:0];
        endfunction

        function bma_pkg::t_result apply_word(t_mouse_word w);
            bma_pkg::t_result r;
            bit [7:0]   m;
            bit [7:0]   bitv;
            int         dx;
            int         dy;
            r = '0;
            m = bma_pkg::IRQ_BASE >> irq_num;
            case (w.action)
                bma_pkg::ACT_READ: begin
                    case (w.port)
                        bma_pkg::PORT_DATA: begin
                            case (ctrl[6:5])
                                bma_pkg::DSEL_X_LO: begin
                                    r.read_data[3:0] = cnt_x[3:0];
                                    cnt_x[3:0] = '0;
                                end
                                bma_pkg::DSEL_X_HI: begin
                                    r.read_data[3:0] = cnt_x[7:4];
                                    cnt_x[7:4] = '0;
                                end
                                bma_pkg::DSEL_Y_LO: begin
                                    r.read_data[3:0] = cnt_y[3:0];
                                    cnt_y[3:0] = '0;
                                end
                                default: begin
                                    r.read_data[3:0] = cnt_y[7:4];
                                    cnt_y[7:4] = '0;
                                end
                            endcase
                            r.read_data[7:5] = ~btn_latched;
                        end
                        bma_pkg::PORT_SIG: r.read_data = sig;
                        bma_pkg::PORT_CTRL: begin
                            r.read_data = ctrl;
                            ctrl |= bma_pkg::CTRL_LOW;
                            if (tick_irq_en)
                                ctrl = (ctrl & ~m) | (w.noise ? m : 8'h00);
                        end
                        default: begin
                            r.read_data = enabled ? ((ctrl | bma_pkg::CTRL_LOW) & ~m)
                                                  : bma_pkg::BYTE_ONES;
                        end
                    endcase
                end
                bma_pkg::ACT_WRITE: begin
                    case (w.port)
                        bma_pkg::PORT_DATA: ;
                        bma_pkg::PORT_SIG: sig = w.wdata;
                        bma_pkg::PORT_CTRL: begin
                            ctrl = w.wdata | bma_pkg::CTRL_LOW;
                            tick_irq_en = ~w.wdata[4];
                            hold = w.wdata[7];
                            r.irq_clear = 1'b1;
                        end
                        default: begin
                            if (w.wdata[7]) begin
                                // mode set
                                enabled = 1'b1;
                                tick_irq_en = 1'b1;
                                ctrl = bma_pkg::CTRL_LOW & ~m;
                            end else begin
                                bitv = 8'h01 << w.wdata[3:1];
                                if (w.wdata[0]) ctrl |= bitv;
                                else ctrl &= ~bitv;
                            end
                        end
                    endcase
                end
                bma_pkg::ACT_UPDATE: begin
                    if (!enabled) begin
                        // disabled: nothing changes
                    end else if (w.move_x == 0 && w.move_y == 0 && w.buttons == btn_prev) begin
                        btn_prev = w.buttons;
                    end else begin
                        btn_mapped = {w.buttons[0], three & w.buttons[2], w.buttons[1]};
                        btn_prev = w.buttons;
                        dx = clamp_move(w.move_x);
                        dy = clamp_move(w.move_y);
                        if (timed) begin
                            acc_x = sat_add(acc_x, dx);
                            acc_y = sat_add(acc_y, dy);
                        end else begin
                            if (!hold) begin
                                cnt_x = dx[7:0];
                                cnt_y = dy[7:0];
                                btn_latched = btn_mapped;
                            end
                            r.irq_raise = 1'b1;
                        end
                    end
                end
                default: begin
                    if (timed) begin
                        r.irq_raise = tick_irq_en;
                        if (!hold) begin
                            cnt_x = drain_chunk(acc_x);
                            cnt_y = drain_chunk(acc_y);
                            btn_latched = btn_mapped;
                        end
                    end
                end
            endcase
            return r;
        endfunction

        function void take_word(t_mouse_word w);
            replies_due.push_back(apply_word(w));
        endfunction

        function void check_reply(bma_pkg::t_result got);
            bma_pkg::t_result want;
            if (replies_due.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected reply: rd=%02h raise=%0b clear=%0b",
                             got.read_data, got.irq_raise, got.irq_clear);
                return;
            end
            want = replies_due.pop_front();
            if (got.read_data !== want.read_data || got.irq_raise !== want.irq_raise ||
                got.irq_clear !== want.irq_clear) begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: expected rd=%02h raise=%0b clear=%0b, got rd=%02h raise=%0b clear=%0b",
                             want.read_data, want.irq_raise, want.irq_clear,
                             got.read_data, got.irq_raise, got.irq_clear);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, channels and the adapter
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [bma_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [bma_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    bma_in_if  in_if ();
    bma_out_if out_if ();

    bus_mouse_adapter_top #(
        .ACC_WIDTH(ACC_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in(in_if.sink),
        .o_out(out_if.source)
    );

    mouse_adapter_tracker tracker;

    int         burst_left = 0;     // words left in the current sender burst
    logic [2:0] host_buttons = '0;  // last buttons sent, for no-change updates

    // ------------------------------------------------------------------
    // Monitor: both channels are sampled at the rising edge. The reply is
    // checked before the new word is noted; the adapter answers in the cycle
    // after acceptance at the earliest, so this order is exact.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        bma_pkg::t_result got;
        t_mouse_word      seen;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                got.read_data = out_if.read_data;
                got.irq_raise = out_if.irq_raise;
                got.irq_clear = out_if.irq_clear;
                tracker.check_reply(got);
            end
            if (in_if.valid && in_if.ready) begin
                seen.action = bma_pkg::t_action'(in_if.action);
                seen.port = bma_pkg::t_port'(in_if.port);
                seen.wdata = in_if.write_data;
                seen.move_x = in_if.move_x;
                seen.move_y = in_if.move_y;
                seen.buttons = in_if.buttons_raw;
                seen.noise = in_if.noise_bit;
                tracker.take_word(seen);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stalls follow their own pattern. The stall rate switches
    // between none, light and heavy at random intervals so that stretches
    // with no back-pressure alternate with frequent stalls.
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        int stall_pct;
        int pattern_left;
        stall_left = 0;
        stall_pct = 0;
        pattern_left = 40;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_if.ready = 1'b0;
                stall_left--;
            end else begin
                out_if.ready = 1'b1;
                if ($urandom_range(99, 0) < stall_pct)
                    stall_left = $urandom_range(5, 1);
            end
            pattern_left--;
            if (pattern_left == 0) begin
                case ($urandom_range(2, 0))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    default: stall_pct = 60;
                endcase
                pattern_left = $urandom_range(80, 20);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks; all are entered and left at a falling edge.
    // ------------------------------------------------------------------
    function automatic t_mouse_word compose_word(bma_pkg::t_action a, bma_pkg::t_port p,
                                                 logic [7:0] wd, int mx, int my,
                                                 logic [2:0] b, logic nz);
        t_mouse_word w;
        w.action = a;
        w.port = p;
        w.wdata = wd;
        w.move_x = mx[15:0];
        w.move_y = my[15:0];
        w.buttons = b;
        w.noise = nz;
        return w;
    endfunction

    // Bursts of random length with random gaps; a zero gap keeps valid high
    // across the burst boundary.
    task automatic send_word(t_mouse_word w);
        if (burst_left == 0) begin
            if ($urandom_range(3, 0) != 0) begin
                in_if.valid = 1'b0;
                repeat ($urandom_range(6, 1)) @(negedge i_clk);
            end
            burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(40, 16)
                                                     : $urandom_range(8, 1);
        end
        burst_left--;
        in_if.action = w.action;
        in_if.port = w.port;
        in_if.write_data = w.wdata;
        in_if.move_x = w.move_x;
        in_if.move_y = w.move_y;
        in_if.buttons_raw = w.buttons;
        in_if.noise_bit = w.noise;
        in_if.valid = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    // Let every outstanding reply come back before a register write.
    task automatic settle();
        in_if.valid = 1'b0;
        burst_left = 0;
        while (tracker.replies_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [bma_pkg::CFG_IDX_W-1:0] idx,
                             logic [bma_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Mostly well-formed traffic: motion and ticks dominate, config writes
    // are mostly bit set/reset, hold is set by a minority of control writes.
    // Unused fields still carry random bits.
    function automatic t_mouse_word random_word();
        t_mouse_word w;
        int          pick;
        w.action = bma_pkg::ACT_READ;
        w.port = bma_pkg::t_port'($urandom_range(3, 0));
        w.wdata = 8'($urandom);
        w.move_x = 16'($urandom);
        w.move_y = 16'($urandom);
        w.buttons = 3'($urandom);
        w.noise = 1'($urandom);
        pick = $urandom_range(99, 0);
        if (pick < 32) begin
            w.action = bma_pkg::ACT_UPDATE;
            case ($urandom_range(9, 0))
                0: ;  // full 16-bit range, exercises the clamp
                1, 2: begin
                    // no change: zero motion, same buttons
                    w.move_x = '0;
                    w.move_y = '0;
                    w.buttons = host_buttons;
                end
                3: begin
                    // buttons only
                    w.move_x = '0;
                    w.move_y = '0;
                end
                default: begin
                    w.move_x = 16'(int'($urandom_range(400, 0)) - 200);
                    w.move_y = 16'(int'($urandom_range(400, 0)) - 200);
                end
            endcase
        end else if (pick < 52) begin
            w.action = bma_pkg::ACT_TICK;
        end else if (pick < 76) begin
            w.action = bma_pkg::ACT_READ;
            pick = $urandom_range(99, 0);
            if (pick < 45) w.port = bma_pkg::PORT_DATA;
            else if (pick < 70) w.port = bma_pkg::PORT_CTRL;
            else if (pick < 85) w.port = bma_pkg::PORT_CFG;
            else w.port = bma_pkg::PORT_SIG;
        end else begin
            w.action = bma_pkg::ACT_WRITE;
            pick = $urandom_range(99, 0);
            if (pick < 40) begin
                w.port = bma_pkg::PORT_CFG;
                w.wdata[7] = ($urandom_range(6, 0) == 0);
            end else if (pick < 70) begin
                w.port = bma_pkg::PORT_CTRL;
                w.wdata[7] = ($urandom_range(3, 0) == 0);
            end else if (pick < 90) begin
                w.port = bma_pkg::PORT_SIG;
            end else begin
                w.port = bma_pkg::PORT_DATA;
            end
        end
        return w;
    endfunction

    // Short directed pass: disabled device, signature, mode set, clamp
    // extremes, no-change update, all four nibble selects, control reads
    // with both noise values, hold, and the ignored data write.
    task automatic run_directed();
        send_word(compose_word(bma_pkg::ACT_READ,   bma_pkg::PORT_CFG,  8'h00, 0, 0, 3'd0, 1'b0));
        send_word(compose_word(bma_pkg::ACT_UPDATE, bma_pkg::PORT_DATA, 8'h00, 5, 5, 3'd1, 1'b0));
        send_word(compose_word(bma_pkg::ACT_TICK,   bma_pkg::PORT_DATA, 8'h00, 0, 0, 3'd0, 1'b0));
        send_word(compose_word(bma_pkg::ACT_READ,   bma_pkg::PORT_DATA, 8'h00, 0, 0, 3'd0, 1'b0));
        send_word(compose_word(bma_pkg::ACT_WRITE,  bma_pkg::PORT_SIG,  8'hff, 0, 0, 3'd0, 1'b0));
        send_word(compose_word(bma_pkg::ACT_READ,   bma_pkg::PORT_SIG,  8'h00, 0, 0, 3'd0, 1'b0));
        send_word(compose_word(bma_pkg::ACT_WRITE,  bma_pkg::PORT_CFG,  8'h80, 0, 0, 3'd0, 1'b0));
        send_word(compose_word(bma_pkg::ACT_READ,   bma_pkg::PORT_CFG,  8'h00, 0, 0, 3'd0, 1'b0));
        send_word(compose_word(bma_pkg::ACT_UPDATE, bma_pkg::PORT_DATA, 8'h00,
                               32767, -32768, 3'd7, 1'b0));
        send_word(compose_word(bma_pkg::ACT_UPDATE, bma_pkg::PORT_DATA, 8'h00, 0, 0, 3'd7, 1'b0));
        send_word(compose_word(bma_pkg::ACT_UPDATE, bma_pkg::PORT_DATA, 8'h00,
                               -200, 300, 3'd4, 1'b0));
        send_word(compose_word(bma_pkg::ACT_TICK,   bma_pkg::PORT_DATA, 8'h00, 0, 0, 3'd0, 1'b0));
        send_word(compose_word(bma_pkg::ACT_READ,   bma_pkg::PORT_DATA, 8'h00, 0, 0, 3'd0, 1'b0));
        send_word(compose_word(bma_pkg::ACT_WRITE,  bma_pkg::PORT_CFG,  8'h0b, 0, 0, 3'd0, 1'b0));
        send_word(compose_word(bma_pkg::ACT_READ,   bma_pkg::PORT_DATA, 8'h00, 0, 0, 3'd0, 1'b0));
        send_word(compose_word(bma_pkg::ACT_WRITE,  bma_pkg::PORT_CFG,  8'h0d, 0, 0, 3'd0, 1'b0));
        send_word(compose_word(bma_pkg::ACT_READ,   bma_pkg::PORT_DATA, 8'h00, 0, 0, 3'd0, 1'b0));
        send_word(compose_word(bma_pkg::ACT_WRITE,  bma_pkg::PORT_CFG,  8'h0a, 0, 0, 3'd0, 1'b0));
        send_word(compose_word(bma_pkg::ACT_READ,   bma_pkg::PORT_DATA, 8'h00, 0, 0, 3'd0, 1'b0));
        send_word(compose_word(bma_pkg::ACT_READ,   bma_pkg::PORT_CTRL, 8'h00, 0, 0, 3'd0, 1'b1));
        send_word(compose_word(bma_pkg::ACT_READ,   bma_pkg::PORT_CTRL, 8'h00, 0, 0, 3'd0, 1'b0));
        send_word(compose_word(bma_pkg::ACT_WRITE,  bma_pkg::PORT_CTRL, 8'h90, 0, 0, 3'd0, 1'b0));
        send_word(compose_word(bma_pkg::ACT_TICK,   bma_pkg::PORT_DATA, 8'h00, 0, 0, 3'd0, 1'b0));
        send_word(compose_word(bma_pkg::ACT_UPDATE, bma_pkg::PORT_DATA, 8'h00, 1, 1, 3'd0, 1'b0));
        send_word(compose_word(bma_pkg::ACT_WRITE,  bma_pkg::PORT_CTRL, 8'h00, 0, 0, 3'd0, 1'b0));
        send_word(compose_word(bma_pkg::ACT_WRITE,  bma_pkg::PORT_DATA, 8'h55, 0, 0, 3'd0, 1'b0));
    endtask

    // Drive both accumulators into saturation (X high, Y low), then drain
    // six chunks and read them back.
    task automatic run_saturation();
        t_mouse_word w;
        send_word(compose_word(bma_pkg::ACT_WRITE, bma_pkg::PORT_CTRL, 8'h00, 0, 0, 3'd0, 1'b0));
        for (int k = 0; k < 300; k++) begin
            w = random_word();
            if ($urandom_range(19, 0) != 0) begin
                w.action = bma_pkg::ACT_UPDATE;
                w.move_x = 16'($urandom_range(32767, 128));
                w.move_y = 16'(-int'($urandom_range(32768, 129)));
            end
            if (w.action == bma_pkg::ACT_WRITE) w.wdata[7] = 1'b0;
            send_word(w);
        end
        for (int k = 0; k < 6; k++) begin
            send_word(compose_word(bma_pkg::ACT_TICK, bma_pkg::PORT_DATA, 8'($urandom), 0, 0,
                                   3'($urandom), 1'($urandom)));
            send_word(compose_word(bma_pkg::ACT_READ, bma_pkg::PORT_DATA, 8'($urandom), 0, 0,
                                   3'($urandom), 1'($urandom)));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        bit [2:0]    irq_order [8];
        bit          timed_sel;
        t_mouse_word w;
        int          waited;
        irq_order = '{3'd5, 3'd2, 3'd7, 3'd6, 3'd0, 3'd3, 3'd1, 3'd4};
        tracker = new();
        in_if.valid = 1'b0;
        in_if.action = '0;
        in_if.port = '0;
        in_if.write_data = '0;
        in_if.move_x = '0;
        in_if.move_y = '0;
        in_if.buttons_raw = '0;
        in_if.noise_bit = 1'b0;

        // reset held from the start, released at a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed pass: timed, three buttons, IRQ 5
        write_cfg(bma_pkg::CFG_TIMED, 3'b001);
        write_cfg(bma_pkg::CFG_THREE, 3'b001);
        write_cfg(bma_pkg::CFG_IRQ_NUM, 3'd5);
        run_directed();

        // random phases, each under its own register setting; IRQ numbers
        // sweep 0..7 including the ones with no IRQ bit
        for (int p = 0; p < 8; p++) begin
            settle();
            timed_sel = p[0] ^ p[2];
            write_cfg(bma_pkg::CFG_TIMED, {2'($urandom), timed_sel});
            write_cfg(bma_pkg::CFG_THREE, {2'($urandom), p[1]});
            write_cfg(bma_pkg::CFG_IRQ_NUM, irq_order[p]);
            if (p == 3) write_cfg(CFG_SPARE, 3'($urandom));
            for (int k = 0; k < 26; k++) begin
                w = random_word();
                if (w.action == bma_pkg::ACT_UPDATE) host_buttons = w.buttons;
                send_word(w);
            end
        end

        settle();
        write_cfg(bma_pkg::CFG_TIMED, 3'b111);
        write_cfg(bma_pkg::CFG_THREE, 3'b001);
        write_cfg(bma_pkg::CFG_IRQ_NUM, 3'd4);
        run_saturation();

        // wait for the last replies, bounded
        in_if.valid = 1'b0;
        waited = 0;
        while (tracker.replies_due.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);

        if (tracker.failures == 0 && tracker.replies_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
